// ===== sv/first_fit_region_allocator_top_macros.svh =====
// assertion helpers for the region allocator
`ifndef FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during rst
`define FFRA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FFRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FFRA_ASSERT_IMP(label, ante, cons, msg)
`define FFRA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/ffra_pkg.sv =====
`default_nettype none

package ffra_pkg;

  // occupancy map word: one bit per unit, set means used
  localparam int WORD_BITS = 16;
  localparam int WORD_LSB  = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_WAIT      = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_FREED     = 2'd3
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  slot;
    logic [10:0] size;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  base;
    logic [9:0]  last_unit;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_MARK_RD,
    S_MARK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                found;
    logic [WORD_LSB-1:0] pos;
  } scan_hit_t;

endpackage

`default_nettype wire

// ===== sv/ffra_word_scan.sv =====
`default_nettype none

module ffra_word_scan #(
  parameter int CW = 11
) (
  input  logic [ffra_pkg::WORD_BITS-1:0] word,
  input  logic [CW-1:0]                  carry_in,
  input  logic [CW-1:0]                  len,
  output ffra_pkg::scan_hit_t            fit,
  output logic [CW-1:0]                  carry_out
);
  import ffra_pkg::*;

  logic [WORD_BITS-1:0][CW-1:0] run;

  // free run ending at each bit: distance to the nearest used bit below,
  // or the run carried in from lower words when the word is free up to here
  always_comb begin : lanes
    logic                seen;
    logic [WORD_LSB-1:0] last_used;
    for (int j = 0; j < WORD_BITS; j++) begin
      seen      = 1'b0;
      last_used = '0;
      for (int k = 0; k <= j; k++) begin
        if (word[k]) begin
          seen      = 1'b1;
          last_used = WORD_LSB'(k);
        end
      end
      if (seen) begin
        run[j] = CW'(WORD_LSB'(j) - last_used);
      end else begin
        run[j] = carry_in + CW'(j + 1);
      end
    end
  end

  // lowest bit at which the run first reaches the requested length
  always_comb begin
    fit.found = 1'b0;
    fit.pos   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (run[j] >= len) begin
        fit.found = 1'b1;
        fit.pos   = WORD_LSB'(j);
      end
    end
  end

  assign carry_out = run[WORD_BITS-1];

endmodule

`default_nettype wire

// ===== sv/first_fit_region_allocator_top.sv =====
`default_nettype none
`include "first_fit_region_allocator_top_macros.svh"

// First-fit region allocator. The occupancy map sits in one single-port-read
// RAM of 16-unit words; after reset it is cleared one word a cycle, and the
// block takes no request until the clear is done. Requests are handled one at
// a time. An allocate scans the map from word 0, one word per cycle through
// the RAM read port, then marks the chosen run word by word with a
// read-modify-write. A free reads the slot record and clears the run the same
// way. Rejected requests, allocates into a busy slot and empty frees go
// straight to the response. The result is held in an output register, so a
// stalled response does not hold up the next request until that one has a
// result.
module first_fit_region_allocator_top #(
  parameter int MEM_UNITS = 1024,
  parameter int NUM_SLOTS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ffra_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ffra_pkg::rsp_t rsp
);
  import ffra_pkg::*;

  localparam int WORDS = (MEM_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int UW    = WAW + WORD_LSB;
  localparam int CW    = UW + 1;
  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  state_t         state, state_next;
  logic [WAW-1:0] clr_word, clr_word_next;
  logic [WAW-1:0] scan_word, scan_word_next;
  logic [CW-1:0]  carry, carry_next;
  logic [CW-1:0]  len, len_next;
  logic           fill, fill_next;
  logic [UW-1:0]  lo, lo_next;
  logic [UW-1:0]  hi, hi_next;
  logic [WAW-1:0] mk_word, mk_word_next;
  logic [SW-1:0]  slot_idx, slot_idx_next;
  logic [NUM_SLOTS-1:0] busy;
  rsp_t           res, res_next;
  logic           push;
  logic           busy_set, busy_clr, slot_we;

  // occupancy map
  logic [WORD_BITS-1:0] map_mem [WORDS];
  logic [WAW-1:0]       map_rd_addr, map_wr_addr;
  logic [WORD_BITS-1:0] map_rdata, map_wdata;
  logic                 map_we;

  // slot records, meaningful only while the slot is busy
  logic [UW-1:0] slot_base_mem [NUM_SLOTS];
  logic [UW-1:0] slot_last_mem [NUM_SLOTS];
  logic [SW-1:0] slot_rd_addr;
  logic [UW-1:0] slot_rd_base, slot_rd_last;

  logic                 req_slot_ok, req_size_ok;
  logic [WORD_BITS-1:0] scan_word_bits;
  scan_hit_t            fit;
  logic [CW-1:0]        scan_carry;
  logic [UW-1:0]        hit_unit, scan_start;
  logic [WORD_BITS-1:0] mark_mask;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wr_addr] <= map_wdata;
    end
    map_rdata <= map_mem[map_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_base_mem[slot_idx] <= lo;
      slot_last_mem[slot_idx] <= hi;
    end
    slot_rd_base <= slot_base_mem[slot_rd_addr];
    slot_rd_last <= slot_last_mem[slot_rd_addr];
  end

  assign req_slot_ok = int'(req.slot) < NUM_SLOTS;
  assign req_size_ok = (req.size != '0) && (int'(req.size) < MEM_UNITS);

  // units past the end of memory in the top word count as used
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      scan_word_bits[k] = map_rdata[k] ||
                          (int'({scan_word, WORD_LSB'(k)}) >= MEM_UNITS);
    end
  end

  ffra_word_scan #(
    .CW (CW)
  ) u_scan (
    .word      (scan_word_bits),
    .carry_in  (carry),
    .len       (len),
    .fit       (fit),
    .carry_out (scan_carry)
  );

  assign hit_unit   = {scan_word, fit.pos};
  assign scan_start = UW'({1'b0, hit_unit} + CW'(1) - len);

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      mark_mask[k] = ({mk_word, WORD_LSB'(k)} >= lo) && ({mk_word, WORD_LSB'(k)} <= hi);
    end
  end

  always_comb begin
    state_next     = state;
    clr_word_next  = clr_word;
    scan_word_next = scan_word;
    carry_next     = carry;
    len_next       = len;
    fill_next      = fill;
    lo_next        = lo;
    hi_next        = hi;
    mk_word_next   = mk_word;
    slot_idx_next  = slot_idx;
    res_next       = res;
    req_stall      = 1'b1;
    map_rd_addr    = '0;
    map_we         = 1'b0;
    map_wr_addr    = mk_word;
    map_wdata      = '0;
    slot_rd_addr   = slot_idx;
    slot_we        = 1'b0;
    busy_set       = 1'b0;
    busy_clr       = 1'b0;
    push           = 1'b0;

    unique case (state)
      S_CLEAR: begin
        map_we        = 1'b1;
        map_wr_addr   = clr_word;
        map_wdata     = '0;
        clr_word_next = clr_word + 1'b1;
        if (clr_word == WAW'(WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        req_stall    = 1'b0;
        slot_rd_addr = SW'(req.slot);
        if (req_valid) begin
          slot_idx_next  = SW'(req.slot);
          len_next       = CW'(req.size);
          carry_next     = '0;
          scan_word_next = '0;
          if (req.opcode == OP_FREE) begin
            if (req_slot_ok && busy[SW'(req.slot)]) begin
              state_next = S_FREE_RD;
            end else begin
              res_next   = '{status: STAT_FREED, base: '0, last_unit: '0};
              state_next = S_RESP;
            end
          end else if (!req_slot_ok || !req_size_ok) begin
            res_next   = '{status: STAT_TOO_LARGE, base: '0, last_unit: '0};
            state_next = S_RESP;
          end else if (busy[SW'(req.slot)]) begin
            res_next   = '{status: STAT_WAIT, base: '0, last_unit: '0};
            state_next = S_RESP;
          end else begin
            // word 0 is being read this cycle
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        map_rd_addr = scan_word + 1'b1;
        if (fit.found) begin
          lo_next      = scan_start;
          hi_next      = hit_unit;
          fill_next    = 1'b1;
          mk_word_next = scan_start[UW-1:WORD_LSB];
          state_next   = S_MARK_RD;
        end else if (scan_word == WAW'(WORDS - 1)) begin
          res_next   = '{status: STAT_WAIT, base: '0, last_unit: '0};
          state_next = S_RESP;
        end else begin
          scan_word_next = scan_word + 1'b1;
          carry_next     = scan_carry;
        end
      end

      S_FREE_RD: begin
        lo_next      = slot_rd_base;
        hi_next      = slot_rd_last;
        fill_next    = 1'b0;
        mk_word_next = slot_rd_base[UW-1:WORD_LSB];
        state_next   = S_MARK_RD;
      end

      S_MARK_RD: begin
        map_rd_addr = mk_word;
        state_next  = S_MARK;
      end

      S_MARK: begin
        // write back this word while the next one is read
        map_we      = 1'b1;
        map_wr_addr = mk_word;
        map_wdata   = fill ? (map_rdata | mark_mask) : (map_rdata & ~mark_mask);
        map_rd_addr = mk_word + 1'b1;
        if (mk_word == hi[UW-1:WORD_LSB]) begin
          if (fill) begin
            slot_we  = 1'b1;
            busy_set = 1'b1;
            res_next = '{status: STAT_ALLOCATED, base: 10'(lo), last_unit: 10'(hi)};
          end else begin
            busy_clr = 1'b1;
            res_next = '{status: STAT_FREED, base: 10'(lo), last_unit: 10'(hi)};
          end
          state_next = S_RESP;
        end else begin
          mk_word_next = mk_word + 1'b1;
        end
      end

      S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_word <= '0;
      busy     <= '0;
    end else begin
      state    <= state_next;
      clr_word <= clr_word_next;
      if (busy_set) begin
        busy[slot_idx] <= 1'b1;
      end
      if (busy_clr) begin
        busy[slot_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_word <= scan_word_next;
    carry     <= carry_next;
    len       <= len_next;
    fill      <= fill_next;
    lo        <= lo_next;
    hi        <= hi_next;
    mk_word   <= mk_word_next;
    slot_idx  <= slot_idx_next;
    res       <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp <= res;
    end
  end

  `FFRA_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state != S_IDLE, "request accepted but block stayed idle")
  `FFRA_ASSERT_IMP(a_push_has_room, push, !rsp_valid || !rsp_stall, "response overwritten while stalled")
  `FFRA_ASSERT_IMP(a_mark_in_range, state == S_MARK, mk_word <= hi[UW-1:WORD_LSB], "mark walked past end of run")
  `FFRA_ASSERT_IMP(a_scan_len_legal, state == S_SCAN, len != '0 && int'(len) < MEM_UNITS, "scan with illegal length")
  `FFRA_ASSERT_IMP(a_alloc_slot_free, state == S_MARK && fill, !busy[slot_idx], "allocating into a busy slot")

endmodule

`default_nettype wire
